>>> src/crp_pkg.sv
// Shared request codes, queue item type and constants for the Catmull-Rom path evaluator.
`timescale 1ns / 1ps

package crp_pkg;

    // Request type codes carried in req_type.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_POINT   = 2'd1;
    localparam logic [1:0] REQ_TANGENT = 2'd2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Path position constants in Q1.16.
    localparam logic [16:0] T_ONE   = 17'd65536;
    localparam logic [16:0] T_DELTA = 17'd655;
    localparam logic [16:0] T_END   = 17'd64881;

    // One request as it travels through the queue.
    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        t;
    } crp_item_t;

    // Push side of the queue.
    typedef struct packed {
        logic      push;
        crp_item_t item;
    } crp_push_t;

    // Status of the queue as seen by both sides.
    typedef struct packed {
        logic valid;
        logic full;
    } crp_q_status_t;

endpackage

>>> src/crp_front.sv
// Front part: accepts requests, drops those with no effect and queues the rest.
`timescale 1ns / 1ps

module crp_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [5:0]             point_index,
    input  logic signed [31:0]     coord_x,
    input  logic signed [31:0]     coord_y,
    input  logic signed [31:0]     coord_z,
    input  logic [16:0]            path_position,
    input  crp_pkg::crp_q_status_t q_status,
    output crp_pkg::crp_push_t     q_push
);

    logic keep;

    // A write outside the table and an unknown type are accepted and dropped.
    always_comb
    begin
        case (req_type)
            crp_pkg::REQ_WRITE:   keep = ({26'd0, point_index} < 32'(MAX_POINTS));
            crp_pkg::REQ_POINT:   keep = 1'b1;
            crp_pkg::REQ_TANGENT: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    // The front holds off only while the queue is full.
    assign in_stall = q_status.full;

    always_comb
    begin
        q_push.push       = in_valid && !q_status.full && keep;
        q_push.item.kind  = req_type;
        q_push.item.index = point_index;
        q_push.item.x     = coord_x;
        q_push.item.y     = coord_y;
        q_push.item.z     = coord_z;
        q_push.item.t     = path_position;
    end

endmodule

>>> src/crp_queue.sv
// Short request queue that decouples the front from the back.
`timescale 1ns / 1ps

module crp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crp_pkg::crp_push_t     q_push,
    input  logic                   pop,
    output crp_pkg::crp_item_t     q_item,
    output crp_pkg::crp_q_status_t q_status
);

    crp_pkg::crp_item_t                entries_reg [crp_pkg::QUEUE_DEPTH];
    logic [crp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [crp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [crp_pkg::QPTR_W:0]          cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign q_status.valid = (cnt_reg != '0);
    assign q_status.full  = (cnt_reg == (crp_pkg::QPTR_W + 1)'(crp_pkg::QUEUE_DEPTH));
    assign q_item         = entries_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_status.full;
    assign do_pop  = pop && q_status.valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= q_push.item;
        end
    end

endmodule

>>> src/crp_back.sv
// Back part: waypoint table and the sequencer that evaluates points and unit tangents.
`timescale 1ns / 1ps

module crp_back #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [6:0]             n_used,
    input  crp_pkg::crp_q_status_t q_status,
    input  crp_pkg::crp_item_t     q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     out_x,
    output logic signed [31:0]     out_y,
    output logic signed [31:0]     out_z
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int QB = FRAC_BITS + 1;
    localparam int CW = $clog2(QB);
    localparam int DW = 33 + FRAC_BITS;
    localparam logic [31:0] ONE      = 32'(1) << FRAC_BITS;
    localparam logic [63:0] LEN2_MIN = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
    localparam logic [32:0] M_HI     = 33'h0_4000_0000;
    localparam logic [32:0] M_LO     = 33'h0_2000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef enum logic [11:0] {
        B_IDLE  = 12'b0000_0000_0001,
        B_SETUP = 12'b0000_0000_0010,
        B_READ  = 12'b0000_0000_0100,
        B_USQ   = 12'b0000_0000_1000,
        B_AXIS  = 12'b0000_0001_0000,
        B_PDONE = 12'b0000_0010_0000,
        B_CHK   = 12'b0000_0100_0000,
        B_NORM  = 12'b0000_1000_0000,
        B_SQ    = 12'b0001_0000_0000,
        B_SQRT  = 12'b0010_0000_0000,
        B_DIV   = 12'b0100_0000_0000,
        B_OUT   = 12'b1000_0000_0000
    } state_t;

    // Waypoint table and its registered read port.
    vec_t             way_reg [MAX_POINTS];
    vec_t             rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    state_t           state_reg, state_next;
    logic [2:0]       ph_reg, ph_next;
    logic [1:0]       axis_reg, axis_next;
    logic             tan_reg, tan_next;
    logic             pass_reg, pass_next;
    logic             norm_done_reg, norm_done_next;
    logic [16:0]      t_reg, t_next;
    logic [16:0]      tb_reg, tb_next;
    logic [6:0]       idx_reg, idx_next;
    logic [6:0]       i0_reg, i0_next;
    logic [6:0]       i2_reg, i2_next;
    logic [6:0]       i3_reg, i3_next;
    logic [16:0]      u_reg, u_next;
    logic [16:0]      u2_reg, u2_next;
    logic [16:0]      u3_reg, u3_next;
    vec_t             p_reg [4];
    vec_t             p_next [4];
    logic signed [36:0] cb_reg, cb_next;
    logic signed [36:0] cc_reg, cc_next;
    logic signed [36:0] cd_reg, cd_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] pa_next [3];
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic [32:0]      m_reg, m_next;
    logic [63:0]      sv_reg, sv_next;
    logic [63:0]      sr_reg, sr_next;
    logic [63:0]      sb_reg, sb_next;
    logic [31:0]      len_reg, len_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dv_reg, dv_next;
    logic [QB-1:0]    q_reg, q_next;
    logic [CW-1:0]    div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic signed [31:0] out_x_reg, out_x_next;
    logic signed [31:0] out_y_reg, out_y_next;
    logic signed [31:0] out_z_reg, out_z_next;

    // Shared multiplier, registered on every cycle.
    logic signed [36:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [68:0] mul_full;

    // Working values of the current step.
    logic [6:0]         seg;
    logic [16:0]        t_clamp;
    logic [23:0]        scaled;
    logic [6:0]         idx_sel;
    logic [16:0]        u_sel;
    logic signed [31:0] pv [4];
    logic signed [36:0] e0, e1, e2, e3;
    logic signed [63:0] rnd;
    logic signed [31:0] rnd_sat;
    logic [1:0]         d_sel;
    logic signed [32:0] dsel;
    logic [32:0]        dsel_abs;
    logic [32:0]        ad0, ad1, ad2, m_max;
    logic [63:0]        sq_try;
    logic               div_ge;
    logic [QB-1:0]      q_fin;

    function automatic logic signed [31:0] pick(input vec_t v, input logic [1:0] a);
        logic signed [31:0] r;
        case (a)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    assign mul_full = mul_a * mul_b;
    assign pop      = (state_reg == B_IDLE) && q_status.valid;
    assign wr_en    = pop && (q_item.kind == crp_pkg::REQ_WRITE);

    // Segment search for the current position.
    always_comb
    begin
        seg     = n_used - 7'd1;
        t_clamp = (t_reg > crp_pkg::T_ONE) ? crp_pkg::T_ONE : t_reg;
        scaled  = {7'd0, t_clamp} * {17'd0, seg};
        if (n_used == 7'd1)
        begin
            idx_sel = 7'd0;
            u_sel   = 17'd0;
        end
        else if (scaled[23:16] >= {1'b0, seg})
        begin
            idx_sel = seg - 7'd1;
            u_sel   = crp_pkg::T_ONE;
        end
        else
        begin
            idx_sel = scaled[22:16];
            u_sel   = {1'b0, scaled[15:0]};
        end
    end

    // Neighbour values of the current axis, widened for the cubic terms.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pv[k] = pick(p_reg[k], axis_reg);
        end
        e0 = 37'(pv[0]);
        e1 = 37'(pv[1]);
        e2 = 37'(pv[2]);
        e3 = 37'(pv[3]);
    end

    // Halve with round to nearest, ties up, then saturate.
    always_comb
    begin
        rnd = (acc_reg + 64'sd65536) >>> 17;
        if (rnd > 64'sd2147483647)
        begin
            rnd_sat = 32'sh7fff_ffff;
        end
        else if (rnd < -64'sd2147483648)
        begin
            rnd_sat = 32'sh8000_0000;
        end
        else
        begin
            rnd_sat = rnd[31:0];
        end
    end

    // Difference component selected for squaring or division.
    always_comb
    begin
        d_sel = (state_reg == B_SQ) ? ph_reg[1:0] : axis_reg;
        case (d_sel)
            2'd0:    dsel = d_reg[0];
            2'd1:    dsel = d_reg[1];
            default: dsel = d_reg[2];
        endcase
        dsel_abs = mag33(dsel);
        ad0      = mag33(d_reg[0]);
        ad1      = mag33(d_reg[1]);
        ad2      = mag33(d_reg[2]);
        m_max    = ad0;
        if (ad1 > m_max)
        begin
            m_max = ad1;
        end
        if (ad2 > m_max)
        begin
            m_max = ad2;
        end
        sq_try = sr_reg + sb_reg;
        div_ge = (rem_reg >= dv_reg);
        q_fin  = {q_reg[QB-2:0], div_ge};
    end

    // Table read address follows the read phase.
    always_comb
    begin
        case (ph_reg)
            3'd0:    rd_addr = AW'(i0_reg);
            3'd1:    rd_addr = AW'(idx_reg);
            3'd2:    rd_addr = AW'(i2_reg);
            default: rd_addr = AW'(i3_reg);
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == B_USQ)
        begin
            mul_a = (ph_reg == 3'd0) ? {20'd0, u_reg} : {20'd0, prod_reg[32:16]};
            mul_b = {15'd0, u_reg};
        end
        else if (state_reg == B_AXIS)
        begin
            case (ph_reg)
                3'd1:
                begin
                    mul_a = cb_reg;
                    mul_b = {15'd0, u_reg};
                end
                3'd2:
                begin
                    mul_a = cc_reg;
                    mul_b = {15'd0, u2_reg};
                end
                default:
                begin
                    mul_a = cd_reg;
                    mul_b = {15'd0, u3_reg};
                end
            endcase
        end
        else if (state_reg == B_SQ)
        begin
            mul_a = 37'(dsel);
            mul_b = dsel[31:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        axis_next      = axis_reg;
        tan_next       = tan_reg;
        pass_next      = pass_reg;
        norm_done_next = norm_done_reg;
        t_next         = t_reg;
        tb_next        = tb_reg;
        idx_next       = idx_reg;
        i0_next        = i0_reg;
        i2_next        = i2_reg;
        i3_next        = i3_reg;
        u_next         = u_reg;
        u2_next        = u2_reg;
        u3_next        = u3_reg;
        p_next         = p_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        cd_next        = cd_reg;
        acc_next       = acc_reg;
        prod_next      = mul_full[63:0];
        res_next       = res_reg;
        pa_next        = pa_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        sv_next        = sv_reg;
        sr_next        = sr_reg;
        sb_next        = sb_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (q_status.valid)
                begin
                    case (q_item.kind)
                        crp_pkg::REQ_POINT:
                        begin
                            tan_next   = 1'b0;
                            t_next     = q_item.t;
                            state_next = B_SETUP;
                        end
                        crp_pkg::REQ_TANGENT:
                        begin
                            tan_next       = 1'b1;
                            pass_next      = 1'b0;
                            norm_done_next = 1'b0;
                            if (n_used < 7'd2)
                            begin
                                res_next[0] = '0;
                                res_next[1] = '0;
                                res_next[2] = ONE;
                                state_next  = B_OUT;
                            end
                            else
                            begin
                                if (q_item.t >= crp_pkg::T_END)
                                begin
                                    t_next  = q_item.t - crp_pkg::T_DELTA;
                                    tb_next = q_item.t;
                                end
                                else
                                begin
                                    t_next  = q_item.t;
                                    tb_next = q_item.t + crp_pkg::T_DELTA;
                                end
                                state_next = B_SETUP;
                            end
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end

            B_SETUP:
            begin
                idx_next = idx_sel;
                u_next   = u_sel;
                i0_next  = (idx_sel != 7'd0) ? idx_sel - 7'd1 : 7'd0;
                i2_next  = (idx_sel + 7'd1 < seg) ? idx_sel + 7'd1 : seg;
                i3_next  = (idx_sel + 7'd2 < seg) ? idx_sel + 7'd2 : seg;
                if (n_used == 7'd1)
                begin
                    i2_next = 7'd0;
                    i3_next = 7'd0;
                end
                ph_next = 3'd0;
                if (n_used == 7'd0)
                begin
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    state_next  = B_PDONE;
                end
                else
                begin
                    state_next = B_READ;
                end
            end

            B_READ:
            begin
                case (ph_reg)
                    3'd1:    p_next[0] = rd_data_reg;
                    3'd2:    p_next[1] = rd_data_reg;
                    3'd3:    p_next[2] = rd_data_reg;
                    3'd4:    p_next[3] = rd_data_reg;
                    default: p_next    = p_reg;
                endcase
                if (ph_reg == 3'd4)
                begin
                    ph_next    = 3'd0;
                    state_next = B_USQ;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end

            B_USQ:
            begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd1)
                begin
                    u2_next = prod_reg[32:16];
                end
                else if (ph_reg == 3'd2)
                begin
                    u3_next    = prod_reg[32:16];
                    axis_next  = 2'd0;
                    ph_next    = 3'd0;
                    state_next = B_AXIS;
                end
            end

            B_AXIS:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0:
                    begin
                        cb_next  = e2 - e0;
                        cc_next  = (e0 <<< 1) - (e1 + (e1 <<< 2)) + (e2 <<< 2) - e3;
                        cd_next  = e3 - e0 + (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1));
                        acc_next = 64'(e1) <<< 17;
                    end
                    3'd1:
                    begin
                        acc_next = acc_reg;
                    end
                    3'd2, 3'd3, 3'd4:
                    begin
                        acc_next = acc_reg + prod_reg;
                    end
                    default:
                    begin
                        res_next[axis_reg] = rnd_sat;
                        ph_next            = 3'd0;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = B_PDONE;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                endcase
            end

            B_PDONE:
            begin
                if (!tan_reg)
                begin
                    state_next = B_OUT;
                end
                else if (!pass_reg)
                begin
                    pa_next    = res_reg;
                    t_next     = tb_reg;
                    pass_next  = 1'b1;
                    state_next = B_SETUP;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        d_next[k] = 33'(res_reg[k]) - 33'(pa_reg[k]);
                    end
                    state_next = B_CHK;
                end
            end

            B_CHK:
            begin
                m_next  = m_max;
                ph_next = 3'd0;
                if (m_max >= M_HI)
                begin
                    state_next = B_NORM;
                end
                else
                begin
                    state_next = B_SQ;
                end
            end

            // One bit of rescaling a cycle until the largest part is in range.
            B_NORM:
            begin
                if (m_reg >= M_HI)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        d_next[k] = (d_reg[k] + $signed({32'd0, d_reg[k][32]})) >>> 1;
                    end
                    m_next = m_reg >> 1;
                end
                else if (m_reg < M_LO)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        d_next[k] = d_reg[k] <<< 1;
                    end
                    m_next = m_reg << 1;
                end
                else
                begin
                    norm_done_next = 1'b1;
                    ph_next        = 3'd0;
                    state_next     = B_SQ;
                end
            end

            B_SQ:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0:
                    begin
                        acc_next = acc_reg;
                    end
                    3'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    3'd2, 3'd3:
                    begin
                        acc_next = acc_reg + prod_reg;
                    end
                    default:
                    begin
                        ph_next = 3'd0;
                        if (norm_done_reg)
                        begin
                            sv_next    = acc_reg;
                            sr_next    = '0;
                            sb_next    = 64'd1 << 62;
                            state_next = B_SQRT;
                        end
                        else if (acc_reg > $signed(LEN2_MIN))
                        begin
                            state_next = B_NORM;
                        end
                        else
                        begin
                            res_next[0] = '0;
                            res_next[1] = '0;
                            res_next[2] = ONE;
                            state_next  = B_OUT;
                        end
                    end
                endcase
            end

            // Integer square root, two radicand bits a cycle.
            B_SQRT:
            begin
                if (sv_reg >= sq_try)
                begin
                    sv_next = sv_reg - sq_try;
                    sr_next = (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sb_next = sb_reg >> 2;
                if (sb_reg == 64'd1)
                begin
                    len_next   = sr_next[31:0];
                    axis_next  = 2'd0;
                    ph_next    = 3'd0;
                    state_next = B_DIV;
                end
            end

            // Restoring division, one quotient bit a cycle.
            B_DIV:
            begin
                if (ph_reg == 3'd0)
                begin
                    rem_next     = (DW'(dsel_abs) << FRAC_BITS) + DW'(len_reg >> 1);
                    dv_next      = DW'(len_reg) << FRAC_BITS;
                    q_next       = '0;
                    div_cnt_next = '0;
                    ph_next      = 3'd1;
                end
                else
                begin
                    rem_next     = div_ge ? rem_reg - dv_reg : rem_reg;
                    dv_next      = dv_reg >> 1;
                    q_next       = q_fin;
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CW'(QB - 1))
                    begin
                        res_next[axis_reg] = dsel[32] ? -$signed(32'(q_fin)) : $signed(32'(q_fin));
                        ph_next            = 3'd0;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = B_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                end
            end

            B_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = res_reg[0];
                    out_y_next     = res_reg[1];
                    out_z_next     = res_reg[2];
                    state_next     = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ph_reg        <= '0;
            axis_reg      <= '0;
            tan_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            norm_done_reg <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            axis_reg      <= axis_next;
            tan_reg       <= tan_next;
            pass_reg      <= pass_next;
            norm_done_reg <= norm_done_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        tb_reg    <= tb_next;
        idx_reg   <= idx_next;
        i0_reg    <= i0_next;
        i2_reg    <= i2_next;
        i3_reg    <= i3_next;
        u_reg     <= u_next;
        u2_reg    <= u2_next;
        u3_reg    <= u3_next;
        p_reg     <= p_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
        cd_reg    <= cd_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        pa_reg    <= pa_next;
        d_reg     <= d_next;
        m_reg     <= m_next;
        sv_reg    <= sv_next;
        sr_reg    <= sr_next;
        sb_reg    <= sb_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        q_reg     <= q_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_z_reg <= out_z_next;
    end

    // Waypoint table: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            way_reg[AW'(q_item.index)] <= '{x: q_item.x, y: q_item.y, z: q_item.z};
        end
        rd_data_reg <= way_reg[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

endmodule

>>> src/catmull_rom_path_eval.sv
// Top level of the uniform Catmull-Rom path evaluator.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    req_type, point_index, coord_x/y/z, path_position
// cfg      input      cfg_valid / cfg_ready  cfg_data (point_count)
// out      output     out_valid / out_stall  out_x, out_y, out_z
//
// A write request updates the table when the back takes it from the queue and gives no
// result. A point request evaluates one point. A tangent request with fewer than two points
// or with a zero-length difference ends early; otherwise it takes two point evaluations on
// the shared multiplier, up to 27 rescaling steps, a 32-step square root and three
// divisions.
// Reset clears control state only; the table is undefined until written.
// Up to four requests wait in the queue while the back is busy or the output is stalled.
`timescale 1ns / 1ps

module catmull_rom_path_eval #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [16:0]        path_position,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    logic [6:0]             count_reg, count_next;
    logic [6:0]             n_used;
    crp_pkg::crp_push_t     q_push;
    crp_pkg::crp_item_t     q_item;
    crp_pkg::crp_q_status_t q_status;
    logic                   pop;

    // Point count register; the count in use saturates at the table size.
    assign cfg_ready  = 1'b1;
    assign count_next = (cfg_valid && cfg_ready) ? cfg_data : count_reg;
    assign n_used     = ({25'd0, count_reg} > 32'(MAX_POINTS)) ? 7'(MAX_POINTS) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    crp_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .path_position (path_position),
        .q_status      (q_status),
        .q_push        (q_push)
    );

    crp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_item   (q_item),
        .q_status (q_status)
    );

    crp_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_used    (n_used),
        .q_status  (q_status),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

endmodule

>>> src/crp_checker.sv
// Port-level checks on the path evaluator, bound to its top level.
`timescale 1ns / 1ps

module crp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z))
        else $error("stalled result changed");

    // While in reset the queue is empty and no result is offered.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !in_stall && !out_valid)
        else $error("activity during reset");

    // No result can be ready in the first cycle after reset is released.
    a_no_early_result: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result straight after reset");

    // The configuration port never holds off a write once out of reset; checked where $past(in_valid) holds.
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && $past(in_valid) |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind catmull_rom_path_eval crp_checker u_crp_checker (.*);
